>>> hdl/dwe_pkg.sv
// Package for the delimited word extractor: character constants, byte class
// functions, register indexes and shared types.
// No dependencies; imported by every module of the block.
package dwe_pkg;

  // Default width of the byte position counter
  localparam int unsigned PositionBitsDef = 32;

  // Field widths fixed by the stream format
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned LenBits   = 9;   // holds the saturation value
  localparam int unsigned OutLenBits = 8;
  localparam int unsigned StartBits = 32;
  localparam int unsigned OutBits   = StartBits + OutLenBits;

  // Word length saturates here, above any programmable maximum
  localparam logic [LenBits-1:0] LenSat = 9'd256;

  // Register reset values
  localparam logic [ByteBits-1:0] MinLenRst = 8'd1;
  localparam logic [ByteBits-1:0] MaxLenRst = 8'd64;

  // Character codes
  localparam logic [ByteBits-1:0] ChLowA  = 8'h61;  // a
  localparam logic [ByteBits-1:0] ChLowZ  = 8'h7A;  // z
  localparam logic [ByteBits-1:0] ChUpA   = 8'h41;  // A
  localparam logic [ByteBits-1:0] ChUpZ   = 8'h5A;  // Z
  localparam logic [ByteBits-1:0] ChNul   = 8'h00;
  localparam logic [ByteBits-1:0] ChTab   = 8'h09;
  localparam logic [ByteBits-1:0] ChLf    = 8'h0A;
  localparam logic [ByteBits-1:0] ChCr    = 8'h0D;
  localparam logic [ByteBits-1:0] ChSpace = 8'h20;
  localparam logic [ByteBits-1:0] ChBang  = 8'h21;  // !
  localparam logic [ByteBits-1:0] ChDquot = 8'h22;  // "
  localparam logic [ByteBits-1:0] ChSquot = 8'h27;  // '
  localparam logic [ByteBits-1:0] ChStar  = 8'h2A;  // *
  localparam logic [ByteBits-1:0] ChComma = 8'h2C;  // ,
  localparam logic [ByteBits-1:0] ChDash  = 8'h2D;  // -
  localparam logic [ByteBits-1:0] ChDot   = 8'h2E;  // .
  localparam logic [ByteBits-1:0] ChColon = 8'h3A;  // :
  localparam logic [ByteBits-1:0] ChSemi  = 8'h3B;  // ;
  localparam logic [ByteBits-1:0] ChQmark = 8'h3F;  // ?

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MIN_LEN = 1'b0,
    REG_MAX_LEN = 1'b1
  } cfg_reg_t;

  // Per-word flags carried between the state registers and the step logic
  typedef struct packed {
    logic in_word;      // a word is open
    logic preceded;     // byte before the open word was a delimiter
    logic last_delim;   // previous byte was a delimiter
  } word_flags_t;

  // ASCII letter test
  function automatic logic is_letter(input logic [ByteBits-1:0] b);
    return b inside {[ChLowA:ChLowZ], [ChUpA:ChUpZ]};
  endfunction

  // Delimiter set test
  function automatic logic is_delim(input logic [ByteBits-1:0] b);
    return b inside {ChNul, ChSpace, ChTab, ChCr, ChLf,
                     ChComma, ChDot, ChSquot, ChDquot, ChQmark,
                     ChDash, ChColon, ChSemi, ChStar, ChBang};
  endfunction

endpackage

>>> hdl/dwe_step.sv
// Per-byte update of the word tracker: next state and the emit decision.
// Purely combinational; depends on dwe_pkg.
module dwe_step import dwe_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  logic [ByteBits-1:0]      text_byte,
  input  logic                     new_stream,
  input  logic [ByteBits-1:0]      min_len,
  input  logic [ByteBits-1:0]      max_len,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [POSITION_BITS-1:0] start,
  input  logic [LenBits-1:0]       len,
  input  word_flags_t              flags,
  output logic [POSITION_BITS-1:0] pos_nxt,
  output logic [POSITION_BITS-1:0] start_nxt,
  output logic [LenBits-1:0]       len_nxt,
  output word_flags_t              flags_nxt,
  output logic                     emit,
  output logic [StartBits-1:0]     word_start,
  output logic [OutLenBits-1:0]    word_len
);

  logic [POSITION_BITS-1:0] pos_eff;
  logic [LenBits-1:0]       len_eff;
  logic                     in_word_eff;
  logic                     last_delim_eff;
  logic                     letter;
  logic                     delim;
  logic                     len_ok;

  // A new stream restarts the position and drops any open word
  assign pos_eff        = new_stream ? '0 : pos;
  assign len_eff        = new_stream ? '0 : len;
  assign in_word_eff    = new_stream ? 1'b0 : flags.in_word;
  assign last_delim_eff = new_stream ? 1'b1 : flags.last_delim;

  assign letter = is_letter(text_byte);
  assign delim  = is_delim(text_byte);
  assign len_ok = (len_eff >= {1'b0, min_len}) && (len_eff <= {1'b0, max_len});

  // Word open / extend / close
  always_comb begin
    start_nxt            = start;
    len_nxt              = len_eff;
    flags_nxt.in_word    = in_word_eff;
    flags_nxt.preceded   = flags.preceded;
    flags_nxt.last_delim = delim;
    emit                 = 1'b0;
    if (letter) begin
      if (!in_word_eff) begin
        flags_nxt.in_word  = 1'b1;
        start_nxt          = pos_eff;
        len_nxt            = LenBits'(1);
        flags_nxt.preceded = last_delim_eff;
      end else if (len_eff < LenSat) begin
        len_nxt = len_eff + LenBits'(1);
      end
    end else if (in_word_eff) begin
      emit              = len_ok && flags.preceded && delim;
      flags_nxt.in_word = 1'b0;
    end
  end

  assign pos_nxt    = pos_eff + POSITION_BITS'(1);
  assign word_start = StartBits'(start);
  assign word_len   = len_eff[OutLenBits-1:0];

endmodule

>>> hdl/delimited_word_extractor_unit.sv
// Top level of the delimited word extractor: stream ports, state registers,
// configuration registers and a two-entry result buffer.
// Depends on dwe_pkg and dwe_step.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------
//  in_      | in  | in_tvalid/tready   | tdata: text_byte; tuser: new_stream
//  out_     | out | out_tvalid/tready  | tdata: word_start, word_len
//  cfg_     | in  | cfg_valid/ready    | cfg_index, cfg_data (min/max length)
//
// One byte is taken per cycle while in_tready is high; the result of an accepted
// closing byte is registered. Tracker state is updated at the accepting edge.
// Reset (synchronous, rst_n low) clears the tracker and the result buffer.
// When the sink stalls, one further result waits in the skid register;
// in_tready drops only while that register is occupied.
module delimited_word_extractor_unit import dwe_pkg::*; #(
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ByteBits-1:0]  in_tdata,    // [7:0] text_byte
  input  logic                 in_tuser,    // [0] new_stream
  // word results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutBits-1:0]   out_tdata,   // [31:0] word_start, [39:32] word_len
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [ByteBits-1:0]  cfg_data
);

  logic [ByteBits-1:0]      min_len_r;
  logic [ByteBits-1:0]      max_len_r;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LenBits-1:0]       len_r, len_nxt;
  word_flags_t              flags_r, flags_nxt;
  logic                     emit;
  logic [StartBits-1:0]     word_start;
  logic [OutLenBits-1:0]    word_len;
  logic                     in_acc;
  logic                     drain;
  logic                     out_vld_r;
  logic [OutBits-1:0]       out_data_r;
  logic                     skid_vld_r;
  logic [OutBits-1:0]       skid_data_r;
  logic [OutBits-1:0]       res_data;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign drain     = out_vld_r && out_tready;
  assign res_data  = {word_len, word_start};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MinLenRst;
      max_len_r <= MaxLenRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_LEN: min_len_r <= cfg_data;
        REG_MAX_LEN: max_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-byte step logic
  dwe_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .text_byte  (in_tdata),
    .new_stream (in_tuser),
    .min_len    (min_len_r),
    .max_len    (max_len_r),
    .pos        (pos_r),
    .start      (start_r),
    .len        (len_r),
    .flags      (flags_r),
    .pos_nxt    (pos_nxt),
    .start_nxt  (start_nxt),
    .len_nxt    (len_nxt),
    .flags_nxt  (flags_nxt),
    .emit       (emit),
    .word_start (word_start),
    .word_len   (word_len)
  );

  // Tracker state, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      flags_r <= '{in_word: 1'b0, preceded: 1'b0, last_delim: 1'b1};
    end else if (in_acc) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Result register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (drain) begin
        out_data_r <= skid_data_r;
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc && emit) begin
      if (!out_vld_r || drain) begin
        out_vld_r  <= 1'b1;
        out_data_r <= res_data;
      end else begin
        skid_vld_r  <= 1'b1;
        skid_data_r <= res_data;
      end
    end else if (drain) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/dwe_checker.sv
// Port-level checks for the delimited word extractor, bound to the top level.
// Depends on dwe_pkg and delimited_word_extractor_unit.
module dwe_checker import dwe_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutBits-1:0]  out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result buffer
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A new result only follows an accepted byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without an accepted transaction");

  // Input only stalls when both result slots are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // Emitted words have at least one letter
  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutBits-1:StartBits] != '0)
    else $error("zero word length");

endmodule

bind delimited_word_extractor_unit dwe_checker u_dwe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb_delimited_word_extractor_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for delimited_word_extractor_unit: a queue-fed byte driver,
// a result monitor and a word tracker that predicts every emitted word.
// Depends on dwe_pkg and the RTL of the block; needs nothing else.
module tb_delimited_word_extractor_unit import dwe_pkg::*; ();

  localparam int SettleCycles = 8;    // quiet cycles before a register write
  localparam int EndWaitLimit = 4000; // cycles allowed for results to come in at the end
  localparam int EndTail      = 20;

  // Work list entries for the driver
  typedef enum logic [2:0] {
    ACT_BYTE,    // offer one text byte
    ACT_REG,     // register write
    ACT_DRAIN,   // pause until every expected word has come, then settle
    ACT_PACE,    // change idling of sender and receiver
    ACT_HOLD     // receiver holds off for a long stretch
  } act_kind_t;

  typedef struct {
    act_kind_t   kind;
    logic [7:0]  value;
    bit          fresh;     // new_stream
    cfg_reg_t    reg_idx;
    int          arg_a;
    int          arg_b;
  } action_t;

  typedef struct {
    logic [31:0] start;
    logic [7:0]  len;
  } word_t;

  // Tracker state mirrored from the block
  typedef struct {
    logic [31:0] pos;
    bit          in_word;
    logic [31:0] start;
    logic [8:0]  len;
    bit          preceded;
    bit          last_delim;
  } tracker_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteBits-1:0] in_tdata  = '0;   // [7:0] text_byte
  logic                in_tuser  = 1'b0; // [0] new_stream
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutBits-1:0]  out_tdata;        // [31:0] word_start, [39:32] word_len
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [0:0]          cfg_index = '0;
  logic [ByteBits-1:0] cfg_data  = '0;

  action_t  pending_actions[$];
  word_t    expected_words[$];
  tracker_t tracker;
  logic [7:0] min_len;
  logic [7:0] max_len;

  action_t act;
  word_t   next_word;
  bit      offer_byte;
  bit      offer_reg;
  int      settle_left;
  int      send_idle_pct;
  int      recv_stall_pct = 0;
  int      hold_requests  = 0;
  int      hold_cycles    = 0;
  int      hold_seen;
  int      hold_left;
  int      mismatches;
  int      queued_bytes;
  int      end_wait;

  delimited_word_extractor_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock and the single reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte classes
  // ---------------------------------------------------------------------------
  function automatic bit is_alpha(input logic [7:0] b);
    return ((b >= ChUpA) && (b <= ChUpZ)) || ((b >= ChLowA) && (b <= ChLowZ));
  endfunction

  function automatic bit is_separator(input logic [7:0] b);
    case (b)
      ChNul, ChSpace, ChTab, ChCr, ChLf, ChComma, ChDot, ChSquot,
      ChDquot, ChQmark, ChDash, ChColon, ChSemi, ChStar, ChBang: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Word tracker: advances on one accepted byte, returns 1 with the word it closes
  // ---------------------------------------------------------------------------
  function automatic bit track_byte(input logic [7:0] b, input bit fresh, output word_t w);
    bit sep;
    bit hit;
    sep = is_separator(b);
    hit = 1'b0;
    w.start = '0;
    w.len   = '0;
    // new text: position restarts, open word dropped
    if (fresh) begin
      tracker.pos        = '0;
      tracker.in_word    = 1'b0;
      tracker.len        = '0;
      tracker.last_delim = 1'b1;
    end
    if (is_alpha(b)) begin
      if (!tracker.in_word) begin
        tracker.in_word  = 1'b1;
        tracker.start    = tracker.pos;
        tracker.len      = 9'd1;
        tracker.preceded = tracker.last_delim;
      end else if (tracker.len < LenSat) begin
        tracker.len = tracker.len + 9'd1;
      end
    end else if (tracker.in_word) begin
      // closing byte: emit only a bounded, delimited word
      if (tracker.len >= {1'b0, min_len} && tracker.len <= {1'b0, max_len} &&
          tracker.preceded && sep) begin
        w.start = tracker.start;
        w.len   = tracker.len[7:0];
        hit     = 1'b1;
      end
      tracker.in_word = 1'b0;
    end
    tracker.last_delim = sep;
    tracker.pos        = tracker.pos + 32'd1;
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Work list builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_letter();
    int k;
    k = $urandom_range(51);
    return (k < 26) ? ChUpA + 8'(k) : ChLowA + 8'(k - 26);
  endfunction

  function automatic logic [7:0] rand_separator();
    case ($urandom_range(14))
      0:  return ChNul;
      1:  return ChSpace;
      2:  return ChTab;
      3:  return ChCr;
      4:  return ChLf;
      5:  return ChComma;
      6:  return ChDot;
      7:  return ChSquot;
      8:  return ChDquot;
      9:  return ChQmark;
      10: return ChDash;
      11: return ChColon;
      12: return ChSemi;
      13: return ChStar;
      default: return ChBang;
    endcase
  endfunction

  // any byte that is neither a letter nor a delimiter
  function automatic logic [7:0] rand_other();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (is_alpha(b) || is_separator(b)) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit fresh);
    action_t a;
    a.kind = ACT_BYTE; a.value = b; a.fresh = fresh;
    a.reg_idx = REG_MIN_LEN; a.arg_a = 0; a.arg_b = 0;
    pending_actions.push_back(a);
    queued_bytes++;
  endtask

  task automatic push_ctrl(input act_kind_t kind, input cfg_reg_t idx, input int a_val,
                           input int b_val);
    action_t a;
    a.kind = kind; a.value = 8'(a_val); a.fresh = 1'b0;
    a.reg_idx = idx; a.arg_a = a_val; a.arg_b = b_val;
    pending_actions.push_back(a);
  endtask

  // register writes happen only once the block has gone quiet
  task automatic queue_reg_write(input cfg_reg_t idx, input int val);
    push_ctrl(ACT_DRAIN, REG_MIN_LEN, 0, 0);
    push_ctrl(ACT_REG, idx, val, 0);
  endtask

  task automatic queue_bounds(input int lo, input int hi);
    queue_reg_write(REG_MIN_LEN, lo);
    queue_reg_write(REG_MAX_LEN, hi);
  endtask

  task automatic push_word(input int len, input int fresh_pct);
    int i;
    for (i = 0; i < len; i++)
      push_byte(rand_letter(), (i == 0 && $urandom_range(99) < fresh_pct) ||
                               $urandom_range(59) == 0);
  endtask

  // Mostly well-formed words with random content, some noise and broken closers
  task automatic emit_text(input int n_bytes);
    int stop;
    int r;
    int wlen;
    stop = queued_bytes + n_bytes;
    while (queued_bytes < stop) begin
      r = $urandom_range(99);
      if (r < 12) begin
        push_byte(8'($urandom_range(255)), $urandom_range(24) == 0);
      end else begin
        wlen = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(70, 9);
        push_word(wlen, 6);
        if ($urandom_range(99) < 82) push_byte(rand_separator(), $urandom_range(39) == 0);
        else push_byte(rand_other(), 1'b0);
        if ($urandom_range(3) == 0) push_byte(rand_separator(), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: byte and register channels, fed from the work list
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_tdata    <= '0;
      in_tuser    <= 1'b0;
      cfg_valid   <= 1'b0;
      cfg_index   <= REG_MIN_LEN;
      cfg_data    <= '0;
      settle_left = 0;
    end else begin
      // retire completed transactions into the tracker
      if (in_tvalid && in_tready) begin
        if (track_byte(in_tdata, in_tuser, next_word)) expected_words.push_back(next_word);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_LEN: min_len = cfg_data;
          REG_MAX_LEN: max_len = cfg_data;
          default: ;
        endcase
      end
      // offer the next transaction unless one is still waiting
      if (!(in_tvalid && !in_tready) && !(cfg_valid && !cfg_ready)) begin
        offer_byte = 1'b0;
        offer_reg  = 1'b0;
        if (settle_left > 0) begin
          settle_left--;
        end else if (pending_actions.size() > 0) begin
          case (pending_actions[0].kind)
            ACT_BYTE: begin
              if ($urandom_range(99) >= send_idle_pct) begin
                act = pending_actions.pop_front();
                offer_byte = 1'b1;
                in_tdata   <= act.value;
                in_tuser   <= act.fresh;
              end
            end
            ACT_REG: begin
              act = pending_actions.pop_front();
              offer_reg = 1'b1;
              cfg_index <= act.reg_idx;
              cfg_data  <= act.value;
            end
            ACT_DRAIN: begin
              if (expected_words.size() == 0) begin
                act = pending_actions.pop_front();
                settle_left = SettleCycles;
              end
            end
            ACT_PACE: begin
              act = pending_actions.pop_front();
              send_idle_pct  = act.arg_a;
              recv_stall_pct <= act.arg_b;
            end
            ACT_HOLD: begin
              act = pending_actions.pop_front();
              hold_cycles   <= act.arg_a;
              hold_requests <= hold_requests + 1;
            end
            default: act = pending_actions.pop_front();
          endcase
        end
        in_tvalid <= offer_byte;
        cfg_valid <= offer_reg;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus long hold-offs on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_seen  = 0;
      hold_left  = 0;
    end else begin
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = hold_cycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result against the oldest expected word
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with none expected", out_tdata[31:0], '0);
      end else begin
        next_word = expected_words.pop_front();
        if (out_tdata[31:0] !== next_word.start)
          report_mismatch("word_start", out_tdata[31:0], next_word.start);
        if (out_tdata[39:32] !== next_word.len)
          report_mismatch("word_len", 32'(out_tdata[39:32]), 32'(next_word.len));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    mismatches    = 0;
    queued_bytes  = 0;
    send_idle_pct = 0;
    min_len       = MinLenRst;
    max_len       = MaxLenRst;
    tracker.pos        = '0;
    tracker.in_word    = 1'b0;
    tracker.start      = '0;
    tracker.len        = '0;
    tracker.preceded   = 1'b0;
    tracker.last_delim = 1'b1;

    push_ctrl(ACT_PACE, REG_MIN_LEN, 24, 82);

    // Directed: one-letter word at stream start closed by NUL
    push_byte("A", 1'b1); push_byte(ChNul, 1'b0);
    // highest letter code closed by a comma
    push_byte("z", 1'b0); push_byte(ChComma, 1'b0);
    // closed by a non-delimiter: dropped
    push_byte("Z", 1'b0); push_byte("a", 1'b0); push_byte(8'hFF, 1'b0);
    // not preceded by a delimiter: dropped
    push_byte("y", 1'b0); push_byte(ChSpace, 1'b0);
    // open word dropped by a new stream, fresh word at position 0
    push_byte("q", 1'b0); push_byte("Q", 1'b0); push_byte("b", 1'b1); push_byte(ChBang, 1'b0);
    // bytes just outside the letter ranges
    push_byte(8'h40, 1'b0); push_byte(8'h5B, 1'b0); push_byte(8'h60, 1'b0);
    push_byte(8'h7B, 1'b0); push_byte("a", 1'b0); push_byte(ChLf, 1'b0);
    // new stream on a delimiter
    push_byte(ChTab, 1'b1); push_byte("B", 1'b0); push_byte("a", 1'b0); push_byte(ChCr, 1'b0);

    // Reset bounds
    emit_text(40);

    // Widest bounds: an over-long word saturates above the maximum and never passes
    queue_bounds(1, 255);
    push_byte(ChSpace, 1'b0);
    push_word(257, 0); push_byte(ChDot, 1'b0);
    emit_text(10);

    push_ctrl(ACT_PACE, REG_MIN_LEN, 82, 24);
    queue_bounds(3, 5);
    emit_text(50);
    // crossed bounds: nothing may come out
    queue_bounds(10, 4);
    emit_text(20);

    push_ctrl(ACT_PACE, REG_MIN_LEN, 0, 0);
    queue_bounds(1, 1);
    emit_text(20);
    queue_bounds($urandom_range(6, 1), $urandom_range(20, 2));
    emit_text(50);

    // Long receiver hold-off while short words keep coming, then a full pause
    queue_bounds(2, 200);
    push_ctrl(ACT_HOLD, REG_MIN_LEN, 250, 0);
    repeat (16) begin
      push_word(2, 0);
      push_byte(ChSpace, 1'b0);
    end
    push_ctrl(ACT_DRAIN, REG_MIN_LEN, 0, 0);
    emit_text(30);

    // wait for the work list to run dry
    @(negedge clk);
    while (pending_actions.size() > 0 || in_tvalid || cfg_valid) @(negedge clk);
    end_wait = 0;
    while (expected_words.size() > 0 && end_wait < EndWaitLimit) begin
      @(negedge clk);
      end_wait++;
    end
    repeat (EndTail) @(negedge clk);
    if (expected_words.size() > 0)
      report_mismatch("words never delivered", expected_words.size(), 0);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
